@@ rtl/core/dmsh_pkg.sv @@
`default_nettype none
package dmsh_pkg;

   localparam int MAX_LEN = 4096;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int WORD_W  = 31;
   localparam int CSR_IDX_W = 2;

   // Input mode codes.
   localparam logic [1:0] MODE_BEGIN  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   // Operation codes after classification.
   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FIRST     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SECOND    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_FIRST  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_SECOND = 2'd3;

   localparam logic [WORD_W-1:0] RST_BASE_FIRST     = 31'd31;
   localparam logic [WORD_W-1:0] RST_BASE_SECOND    = 31'd37;
   localparam logic [WORD_W-1:0] RST_MODULUS_FIRST  = 31'd1000000007;
   localparam logic [WORD_W-1:0] RST_MODULUS_SECOND = 31'd1000000009;

   typedef struct packed {
      logic [1:0]        mode;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] left_index;
      logic [ADDR_W-1:0] right_index;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] hash_first;
      logic [WORD_W-1:0] hash_second;
      logic [1:0]        status;
      logic [LEN_W-1:0]  string_length_out;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] base_first;
      logic [WORD_W-1:0] base_second;
      logic [WORD_W-1:0] modulus_first;
      logic [WORD_W-1:0] modulus_second;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        op;
      logic              order_bad;
      logic [7:0]        char_code;
      logic [ADDR_W-1:0] left_index;
      logic [ADDR_W-1:0] right_index;
   } item_type;

endpackage
`default_nettype wire

@@ rtl/core/double_mod_substring_hash_top.sv @@
// Channel   Ports                                   Handshake
// request   start, busy, req_data                   taken when start is high and busy low
// result    rsp_valid, rsp_data                     one-cycle strobe, always taken
// config    csr_we, csr_index, csr_wdata            written when csr_we is high
//
// Each modular product runs on one shared shift-and-subtract unit.
// An append uses eight products and a query six, a begin up to 61 products per modulus;
// rejects are answered without a product.
// Reset is synchronous and clears the queue, the sequencer and the length.
// Results cannot be stalled; a two-entry queue takes items while the sequencer works,
// and busy rises only when it is full.
`default_nettype none
module double_mod_substring_hash_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire dmsh_pkg::req_type              req_data,
   output logic                                busy,
   output logic                                rsp_valid,
   output dmsh_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [dmsh_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dmsh_pkg::WORD_W-1:0]    csr_wdata
);
   import dmsh_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     head_valid, pop;
   item_type head;

   // The configuration registers are read live by the sequencer; the user must see
   // that they are only written while no item is in flight. The block does not enforce it.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_FIRST:     cfg_in.base_first     = csr_wdata;
            CSR_BASE_SECOND:    cfg_in.base_second    = csr_wdata;
            CSR_MODULUS_FIRST:  cfg_in.modulus_first  = csr_wdata;
            CSR_MODULUS_SECOND: cfg_in.modulus_second = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_first     <= RST_BASE_FIRST;
         cfg_ff.base_second    <= RST_BASE_SECOND;
         cfg_ff.modulus_first  <= RST_MODULUS_FIRST;
         cfg_ff.modulus_second <= RST_MODULUS_SECOND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end decodes each item and holds it until the sequencer is free.
   dmsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // The back end runs begin, append and query on the shared multiplier.
   dmsh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_FULL |->
      rsp_data.string_length_out == LEN_W'(MAX_LEN))
      else $error("store full reported below capacity");

   a_zero_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
      rsp_data.hash_first == '0 && rsp_data.hash_second == '0)
      else $error("rejected item carries a hash");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.string_length_out <= LEN_W'(MAX_LEN))
      else $error("length beyond capacity");
`endif

endmodule
`default_nettype wire

@@ rtl/core/dmsh_ram.sv @@
`default_nettype none
module dmsh_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ rtl/core/dmsh_mulmod.sv @@
`default_nettype none
module dmsh_mulmod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        go,
   input  wire logic [dmsh_pkg::WORD_W-1:0] a,
   input  wire logic [dmsh_pkg::WORD_W-1:0] b,
   input  wire logic [dmsh_pkg::WORD_W-1:0] m,
   output logic                             done,
   output logic      [dmsh_pkg::WORD_W-1:0] res
);
   import dmsh_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RED  = 2'd1;
   localparam logic [1:0] PH_MUL  = 2'd2;
   localparam logic [4:0] LAST_BIT = 5'(WORD_W - 1);

   logic [1:0]        phase_ff, phase_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [WORD_W-1:0] acc_ff, acc_in, bred_ff, bred_in, res_ff, res_in;
   logic [WORD_W:0]   t_red, t_dbl, dbl, s, m_ext;
   logic [WORD_W-1:0] red, s1;

   // First b is reduced modulo m bit by bit, then a is walked from its top bit
   // with a doubling and a conditional add of the reduced b.
   always_comb begin
      m_ext = {1'b0, m_ff};
      t_red = {acc_ff, b_ff[cnt_ff]};
      red   = (t_red >= m_ext) ? WORD_W'(t_red - m_ext) : t_red[WORD_W-1:0];
      t_dbl = {acc_ff, 1'b0};
      dbl   = (t_dbl >= m_ext) ? (t_dbl - m_ext) : t_dbl;
      s     = dbl + (a_ff[cnt_ff] ? {1'b0, bred_ff} : '0);
      s1    = (s >= m_ext) ? WORD_W'(s - m_ext) : s[WORD_W-1:0];

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      acc_in   = acc_ff;
      bred_in  = bred_ff;
      res_in   = res_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (go) begin
               a_in   = a;
               b_in   = b;
               m_in   = m;
               acc_in = '0;
               cnt_in = LAST_BIT;
               if (m < WORD_W'(2)) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  phase_in = PH_RED;
               end
            end
         end
         PH_RED: begin
            acc_in = red;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               bred_in  = red;
               acc_in   = '0;
               cnt_in   = LAST_BIT;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            acc_in = s1;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               res_in   = s1;
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      acc_ff  <= acc_in;
      bred_ff <= bred_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule
`default_nettype wire

@@ rtl/core/dmsh_front.sv @@
`default_nettype none
module dmsh_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire dmsh_pkg::req_type  req_data,
   output logic                    busy,
   output logic                    head_valid,
   output dmsh_pkg::item_type      head,
   input  wire logic               pop
);
   import dmsh_pkg::*;

   item_type   q_ff [2];
   item_type   q_in [2];
   item_type   cls;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // Decode the mode and check the query bounds that do not depend on length.
   always_comb begin
      case (req_data.mode)
         MODE_BEGIN:  cls.op = OP_BEGIN;
         MODE_APPEND: cls.op = OP_APPEND;
         MODE_QUERY:  cls.op = OP_QUERY;
         default:     cls.op = OP_NONE;
      endcase
      cls.order_bad   = req_data.left_index > req_data.right_index;
      cls.char_code   = req_data.char_code;
      cls.left_index  = req_data.left_index;
      cls.right_index = req_data.right_index;
   end

   assign busy       = cnt_ff == 2'd2;
   assign push       = start && !busy;
   assign head_valid = cnt_ff != 2'd0;
   assign head       = q_ff[rd_ff];

   always_comb begin
      q_in  = q_ff;
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         q_in[wr_ff] = cls;
         wr_in       = !wr_ff;
      end
      if (pop && head_valid) begin
         rd_in = !rd_ff;
      end
      cnt_in = cnt_ff + 2'(push) - 2'(pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/dmsh_back.sv @@
`default_nettype none
module dmsh_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dmsh_pkg::cfg_type  cfg,
   input  wire logic               head_valid,
   input  wire dmsh_pkg::item_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   output dmsh_pkg::rsp_type       rsp_data
);
   import dmsh_pkg::*;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_WAIT = 5'd1;
   localparam logic [4:0] ST_I0   = 5'd2;
   localparam logic [4:0] ST_I1   = 5'd3;
   localparam logic [4:0] ST_I2   = 5'd4;
   localparam logic [4:0] ST_I3   = 5'd5;
   localparam logic [4:0] ST_I4   = 5'd6;
   localparam logic [4:0] ST_A0   = 5'd7;
   localparam logic [4:0] ST_A1   = 5'd8;
   localparam logic [4:0] ST_A2   = 5'd9;
   localparam logic [4:0] ST_A3   = 5'd10;
   localparam logic [4:0] ST_A4   = 5'd11;
   localparam logic [4:0] ST_Q0   = 5'd12;
   localparam logic [4:0] ST_Q1   = 5'd13;
   localparam logic [4:0] ST_Q2   = 5'd14;
   localparam logic [4:0] ST_Q3   = 5'd15;
   localparam logic [4:0] ST_Q4   = 5'd16;
   localparam logic [4:0] ST_Q5   = 5'd17;
   localparam logic [4:0] ST_Q6   = 5'd18;

   localparam logic [WORD_W-1:0] ONE = WORD_W'(1);

   logic [4:0]               state_ff, state_in, ret_ff, ret_in;
   logic                     sel_ff, sel_in;
   item_type                 cur_ff, cur_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [1:0][WORD_W-1:0]   run_ff, run_in, inv_ff, inv_in;
   logic [1:0][WORD_W-1:0]   lpref_ff, lpref_in, linvp_ff, linvp_in;
   logic [1:0][WORD_W-1:0]   h_ff, h_in, hi_ff, hi_in, lo_ff, lo_in, invw_ff, invw_in;
   logic [WORD_W-1:0]        x_ff, x_in, acc_ff, acc_in, sq_ff, sq_in, e_ff, e_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     mm_go, mm_done;
   logic [WORD_W-1:0]        mm_a, mm_b, mm_res, m_sel, base_sel;
   logic                     ram_we;
   logic [ADDR_W-1:0]        pref_raddr, inv_raddr;
   logic [2*WORD_W-1:0]      pref_rdata, inv_rdata;
   logic [WORD_W:0]          sum, diff;

   dmsh_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .go    (mm_go),
      .a     (mm_a),
      .b     (mm_b),
      .m     (m_sel),
      .done  (mm_done),
      .res   (mm_res)
   );

   dmsh_ram #(.WIDTH(2 * WORD_W), .DEPTH(MAX_LEN)) u_pref_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (len_ff[ADDR_W-1:0]),
      .wdata (lpref_ff),
      .raddr (pref_raddr),
      .rdata (pref_rdata)
   );

   dmsh_ram #(.WIDTH(2 * WORD_W), .DEPTH(MAX_LEN)) u_invp_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (len_ff[ADDR_W-1:0]),
      .wdata (linvp_ff),
      .raddr (inv_raddr),
      .rdata (inv_rdata)
   );

   assign m_sel    = sel_ff ? cfg.modulus_second : cfg.modulus_first;
   assign base_sel = sel_ff ? cfg.base_second : cfg.base_first;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      sel_in       = sel_ff;
      cur_in       = cur_ff;
      len_in       = len_ff;
      run_in       = run_ff;
      inv_in       = inv_ff;
      lpref_in     = lpref_ff;
      linvp_in     = linvp_ff;
      h_in         = h_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      invw_in      = invw_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      e_in         = e_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      mm_go        = 1'b0;
      mm_a         = '0;
      mm_b         = '0;
      ram_we       = 1'b0;
      pref_raddr   = cur_ff.right_index;
      inv_raddr    = cur_ff.left_index;
      sum  = {1'b0, x_ff} + {1'b0, mm_res};
      diff = {1'b0, x_ff} + {1'b0, m_sel} - {1'b0, mm_res};

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head;
               sel_in = 1'b0;
               rsp_in.hash_first  = '0;
               rsp_in.hash_second = '0;
               rsp_in.status      = STAT_OK;
               rsp_in.string_length_out = len_ff;
               case (head.op)
                  OP_BEGIN: begin
                     len_in   = '0;
                     run_in   = {ONE, ONE};
                     state_in = ST_I0;
                  end
                  OP_APPEND: begin
                     if (len_ff == LEN_W'(MAX_LEN)) begin
                        rsp_in.status = STAT_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_A0;
                     end
                  end
                  OP_QUERY: begin
                     if (head.order_bad || {1'b0, head.right_index} >= len_ff) begin
                        rsp_in.status = STAT_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_Q0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WAIT: begin
            if (mm_done) begin
               state_in = ret_ff;
            end
         end
         // Inverse by square-and-multiply over the exponent modulus minus two.
         ST_I0: begin
            if (m_sel < WORD_W'(2)) begin
               inv_in[sel_ff] = '0;
               e_in     = '0;
               acc_in   = '0;
               state_in = ST_I1;
            end else begin
               acc_in   = ONE;
               sq_in    = base_sel;
               e_in     = m_sel - WORD_W'(2);
               state_in = ST_I1;
            end
         end
         ST_I1: begin
            if (e_ff == '0) begin
               inv_in[sel_ff] = acc_ff;
               if (!sel_ff) begin
                  sel_in   = 1'b1;
                  state_in = ST_I0;
               end else begin
                  rsp_in.string_length_out = len_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (e_ff[0]) begin
               mm_go    = 1'b1;
               mm_a     = acc_ff;
               mm_b     = sq_ff;
               ret_in   = ST_I2;
               state_in = ST_WAIT;
            end else begin
               state_in = ST_I3;
            end
         end
         ST_I2: begin
            acc_in   = mm_res;
            state_in = ST_I3;
         end
         ST_I3: begin
            mm_go    = 1'b1;
            mm_a     = sq_ff;
            mm_b     = sq_ff;
            ret_in   = ST_I4;
            state_in = ST_WAIT;
         end
         ST_I4: begin
            sq_in    = mm_res;
            e_in     = e_ff >> 1;
            state_in = ST_I1;
         end
         // Append: new prefix, next inverse power, next base power.
         ST_A0: begin
            mm_go    = 1'b1;
            mm_a     = WORD_W'(cur_ff.char_code);
            mm_b     = run_ff[sel_ff];
            ret_in   = ST_A1;
            state_in = ST_WAIT;
         end
         ST_A1: begin
            x_in     = mm_res;
            mm_go    = 1'b1;
            mm_a     = ONE;
            mm_b     = (len_ff == '0) ? '0 : lpref_ff[sel_ff];
            ret_in   = ST_A2;
            state_in = ST_WAIT;
         end
         ST_A2: begin
            lpref_in[sel_ff] = (sum >= {1'b0, m_sel}) ? WORD_W'(sum - {1'b0, m_sel})
                                                       : sum[WORD_W-1:0];
            mm_go    = 1'b1;
            mm_a     = linvp_ff[sel_ff];
            mm_b     = inv_ff[sel_ff];
            ret_in   = ST_A3;
            state_in = ST_WAIT;
         end
         ST_A3: begin
            linvp_in[sel_ff] = (len_ff == '0) ? ONE : mm_res;
            mm_go    = 1'b1;
            mm_a     = run_ff[sel_ff];
            mm_b     = base_sel;
            ret_in   = ST_A4;
            state_in = ST_WAIT;
         end
         ST_A4: begin
            run_in[sel_ff] = mm_res;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_A0;
            end else begin
               ram_we       = 1'b1;
               len_in       = len_ff + LEN_W'(1);
               rsp_in.string_length_out = len_ff + LEN_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         // Query: fetch both prefixes and the inverse power, then reduce.
         ST_Q0: begin
            state_in = ST_Q1;
         end
         ST_Q1: begin
            hi_in      = pref_rdata;
            pref_raddr = cur_ff.left_index - ADDR_W'(1);
            state_in   = ST_Q2;
         end
         ST_Q2: begin
            lo_in    = (cur_ff.left_index == '0) ? '0 : pref_rdata;
            invw_in  = inv_rdata;
            state_in = ST_Q3;
         end
         ST_Q3: begin
            mm_go    = 1'b1;
            mm_a     = ONE;
            mm_b     = hi_ff[sel_ff];
            ret_in   = ST_Q4;
            state_in = ST_WAIT;
         end
         ST_Q4: begin
            x_in     = mm_res;
            mm_go    = 1'b1;
            mm_a     = ONE;
            mm_b     = lo_ff[sel_ff];
            ret_in   = ST_Q5;
            state_in = ST_WAIT;
         end
         ST_Q5: begin
            mm_go    = 1'b1;
            mm_a     = (x_ff >= mm_res) ? (x_ff - mm_res) : diff[WORD_W-1:0];
            mm_b     = invw_ff[sel_ff];
            ret_in   = ST_Q6;
            state_in = ST_WAIT;
         end
         ST_Q6: begin
            h_in[sel_ff] = mm_res;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_Q3;
            end else begin
               rsp_in.hash_first  = h_ff[0];
               rsp_in.hash_second = mm_res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         run_ff       <= {ONE, ONE};
         inv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         run_ff       <= run_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff   <= ret_in;
      sel_ff   <= sel_in;
      cur_ff   <= cur_in;
      lpref_ff <= lpref_in;
      linvp_ff <= linvp_in;
      h_ff     <= h_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      invw_ff  <= invw_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      e_ff     <= e_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ tb/double_mod_substring_hash_top_tb.sv @@
`default_nettype none
module double_mod_substring_hash_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmsh_pkg::*;

   localparam longint unsigned MASK31 = 64'h7FFF_FFFF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   req_type            req_data = '0;
   logic               busy;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BASE_FIRST;
   logic [WORD_W-1:0]  csr_wdata = '0;

   double_mod_substring_hash_top dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Items waiting to be driven, and the results the block still owes us.
   req_type pending_items[$];
   rsp_type owed_hashes[$];

   int unsigned error_count = 0;
   int unsigned items_taken = 0;
   int unsigned results_seen = 0;
   int unsigned begin_count = 0;
   int unsigned full_count = 0;
   int unsigned range_count = 0;
   int unsigned valid_queries = 0;

   // Shadow copy of the hashing state, one slot per modulus.
   longint unsigned shadow_base[2];
   longint unsigned shadow_mod[2];
   logic [30:0]     shadow_prefix[2][MAX_LEN];
   logic [30:0]     shadow_invpow[2][MAX_LEN];
   longint unsigned shadow_run[2];
   longint unsigned shadow_inv[2];
   int unsigned     shadow_len;

   // Modular product of two 31-bit operands; a modulus below two yields zero.
   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
      if (m < 2) return 0;
      return ((a & MASK31) * (b & MASK31)) % m;
   endfunction

   // Base inverse by Fermat: base^(m-2) mod m.
   function automatic longint unsigned fermat_inverse(longint unsigned b, longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned e;
      acc = 1;
      sq = b & MASK31;
      if (m < 2) return 0;
      e = m - 2;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, sq, m);
         sq = mul_mod(sq, sq, m);
         e = e >> 1;
      end
      return acc % m;
   endfunction

   // Works out the result of one accepted item and advances the shadow state.
   function automatic rsp_type hash_item(req_type it);
      rsp_type         res;
      longint unsigned m;
      longint unsigned prev;
      longint unsigned ipw;
      longint unsigned hi;
      longint unsigned lo;
      int unsigned     n;
      int unsigned     l;
      int unsigned     r;
      res = '0;
      l = it.left_index;
      r = it.right_index;
      case (it.mode)
         MODE_BEGIN: begin
            shadow_len = 0;
            for (int k = 0; k < 2; k++) begin
               shadow_run[k] = 1;
               shadow_inv[k] = fermat_inverse(shadow_base[k], shadow_mod[k]);
            end
         end
         MODE_APPEND: begin
            if (shadow_len >= MAX_LEN) begin
               res.status = STAT_FULL;
            end else begin
               n = shadow_len;
               for (int k = 0; k < 2; k++) begin
                  m = shadow_mod[k];
                  prev = (n == 0) ? 0 : shadow_prefix[k][n-1];
                  ipw = (n == 0) ? 1 : mul_mod(shadow_invpow[k][n-1], shadow_inv[k], m);
                  shadow_prefix[k][n] = (m < 2) ? 31'd0 :
                     31'((prev + longint'(it.char_code) * (shadow_run[k] & MASK31)) % m);
                  shadow_invpow[k][n] = 31'(ipw);
                  shadow_run[k] = mul_mod(shadow_run[k], shadow_base[k], m);
               end
               shadow_len++;
            end
         end
         MODE_QUERY: begin
            if (l > r || r >= shadow_len) begin
               res.status = STAT_RANGE;
            end else begin
               for (int k = 0; k < 2; k++) begin
                  m = shadow_mod[k];
                  if (m >= 2) begin
                     hi = shadow_prefix[k][r] % m;
                     lo = (l == 0) ? 0 : shadow_prefix[k][l-1] % m;
                     hi = mul_mod((hi + m - lo) % m, shadow_invpow[k][l], m);
                     if (k == 0) res.hash_first = 31'(hi);
                     else res.hash_second = 31'(hi);
                  end
               end
            end
         end
         default: ;
      endcase
      res.string_length_out = LEN_W'(shadow_len);
      return res;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      error_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Monitor: acceptance, register writes and result checking, all on the rising edge.
   // The driver reads item_taken on the following falling edge.
   bit item_taken = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_base[0] = RST_BASE_FIRST;
         shadow_base[1] = RST_BASE_SECOND;
         shadow_mod[0] = RST_MODULUS_FIRST;
         shadow_mod[1] = RST_MODULUS_SECOND;
         shadow_run = '{1, 1};
         shadow_inv = '{0, 0};
         shadow_len = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_FIRST:     shadow_base[0] = csr_wdata;
               CSR_BASE_SECOND:    shadow_base[1] = csr_wdata;
               CSR_MODULUS_FIRST:  shadow_mod[0] = csr_wdata;
               CSR_MODULUS_SECOND: shadow_mod[1] = csr_wdata;
               default: ;
            endcase
         end
         // A result accepted at this edge belongs to an item accepted earlier,
         // so it is checked before this edge's item is predicted.
         if (rsp_valid) begin
            results_seen++;
            if (owed_hashes.size() == 0) begin
               report_mismatch("result count", results_seen, items_taken);
            end else begin
               want = owed_hashes.pop_front();
               if (rsp_data.hash_first !== want.hash_first)
                  report_mismatch("hash_first", rsp_data.hash_first, want.hash_first);
               if (rsp_data.hash_second !== want.hash_second)
                  report_mismatch("hash_second", rsp_data.hash_second, want.hash_second);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.string_length_out !== want.string_length_out)
                  report_mismatch("string_length_out", rsp_data.string_length_out,
                                  want.string_length_out);
            end
         end
         if (start && !busy) begin
            item_taken = 1;
            items_taken++;
            want = hash_item(req_data);
            if (req_data.mode == MODE_BEGIN) begin_count++;
            if (want.status == STAT_FULL) full_count++;
            if (want.status == STAT_RANGE) range_count++;
            if (req_data.mode == MODE_QUERY && want.status == STAT_OK) valid_queries++;
            owed_hashes.insert(owed_hashes.size(), want);
         end
      end
   end

   // Driver: holds an item until it is taken, then waits out a random gap.
   // With no_gaps set, items go back to back.
   int unsigned gap_left = 0;
   bit          no_gaps = 0;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 150);
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (start && !item_taken) begin
            // Still waiting for the block to take the current item.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            start <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
         item_taken = 0;
      end
   end

   // Stimulus generation. The planned string length tracks what the block will
   // hold so that most queries land inside the stored string.
   int unsigned planned_len = 0;

   function automatic void queue_item(logic [1:0] mode, logic [7:0] ch,
                                      logic [11:0] l, logic [11:0] r);
      req_type it;
      it.mode = mode;
      it.char_code = ch;
      it.left_index = l;
      it.right_index = r;
      pending_items.insert(pending_items.size(), it);
      if (mode == MODE_BEGIN) planned_len = 0;
      else if (mode == MODE_APPEND && planned_len < MAX_LEN) planned_len++;
   endfunction

   function automatic void queue_query();
      int unsigned l;
      int unsigned r;
      if (planned_len > 0 && $urandom_range(0, 9) < 8) begin
         l = $urandom_range(0, planned_len - 1);
         r = $urandom_range(l, planned_len - 1);
      end else begin
         l = $urandom_range(0, 4095);
         r = $urandom_range(0, 4095);
      end
      queue_item(MODE_QUERY, 8'($urandom), 12'(l), 12'(r));
   endfunction

   // One well-formed string: optional begin, a burst of appends, then a mix of
   // queries with a few appends, stray modes and the odd early begin.
   function automatic void queue_string(bit with_begin);
      int unsigned appends;
      int unsigned tail;
      int unsigned roll;
      if (with_begin)
         queue_item(MODE_BEGIN, 8'($urandom), 12'($urandom), 12'($urandom));
      appends = $urandom_range(1, 24);
      for (int i = 0; i < appends; i++)
         queue_item(MODE_APPEND, 8'($urandom), 12'($urandom), 12'($urandom));
      tail = $urandom_range(4, 20);
      for (int i = 0; i < tail; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) queue_query();
         else if (roll < 90)
            queue_item(MODE_APPEND, 8'($urandom), 12'($urandom), 12'($urandom));
         else if (roll < 97)
            queue_item(2'd3, 8'($urandom), 12'($urandom), 12'($urandom));
         else
            queue_item(MODE_BEGIN, 8'($urandom), 12'($urandom), 12'($urandom));
      end
   endfunction

   // Lets every queued item go out and every owed result come back.
   task automatic drain();
      while (pending_items.size() > 0 || start || owed_hashes.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_hashes(logic [WORD_W-1:0] b1, logic [WORD_W-1:0] b2,
                             logic [WORD_W-1:0] m1, logic [WORD_W-1:0] m2);
      write_reg(CSR_BASE_FIRST, b1);
      write_reg(CSR_BASE_SECOND, b2);
      write_reg(CSR_MODULUS_FIRST, m1);
      write_reg(CSR_MODULUS_SECOND, m2);
   endtask

   longint unsigned prime_pool[10] = '{2, 3, 5, 7, 13, 65537, 998244353,
                                       1000000007, 1000000009, 2147483647};

   function automatic logic [WORD_W-1:0] pick_prime();
      return WORD_W'(prime_pool[$urandom_range(0, 9)]);
   endfunction

   function automatic logic [WORD_W-1:0] pick_base(logic [WORD_W-1:0] m);
      if (m <= 2) return 1;
      return WORD_W'($urandom_range(1, m - 1));
   endfunction

   initial begin
      logic [WORD_W-1:0] m1;
      logic [WORD_W-1:0] m2;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on the reset settings. The first appends come before any
      // begin, so the inverse powers are built from a zero inverse.
      queue_item(MODE_APPEND, 8'hFF, 12'h000, 12'hFFF);
      queue_item(MODE_APPEND, 8'h00, 12'hFFF, 12'h000);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd1);
      queue_item(MODE_QUERY, 8'h00, 12'd1, 12'd1);
      queue_item(MODE_QUERY, 8'h00, 12'd1, 12'd0);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd2);
      queue_item(2'd3, 8'hFF, 12'hFFF, 12'hFFF);
      queue_item(MODE_BEGIN, 8'h00, 12'd0, 12'd0);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd0);
      queue_item(MODE_APPEND, 8'h00, 12'd0, 12'd0);
      queue_item(MODE_APPEND, 8'hFF, 12'd0, 12'd0);
      queue_item(MODE_APPEND, 8'h80, 12'd0, 12'd0);
      queue_item(MODE_APPEND, 8'h01, 12'd0, 12'd0);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd3);
      queue_item(MODE_QUERY, 8'h00, 12'd3, 12'd3);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd0);
      queue_item(MODE_QUERY, 8'h00, 12'd2, 12'd1);
      queue_item(MODE_QUERY, 8'h00, 12'd1, 12'd4);
      queue_item(MODE_QUERY, 8'h00, 12'hFFF, 12'hFFF);
      drain();

      // Register extremes: smallest prime with base one, largest 31-bit prime
      // with the largest base below it.
      set_hashes(31'd1, 31'd2147483646, 31'd2, 31'd2147483647);
      queue_string(1);
      drain();

      // Tiny moduli force every product to zero.
      set_hashes(31'd5, 31'h7FFF_FFFF, 31'd0, 31'd1);
      queue_string(1);
      queue_string(1);
      drain();

      // Random phases. One of them keeps the previous string alive across the
      // register change, so the hashes mix old and new settings. Odd phases run
      // back to back with no gaps.
      for (int ph = 0; ph < 10; ph++) begin
         m1 = pick_prime();
         m2 = pick_prime();
         set_hashes(pick_base(m1), pick_base(m2), m1, m2);
         no_gaps = ph[0];
         queue_string(ph != 3);
         while (pending_items.size() < 120) queue_string(1);
         drain();
      end
      no_gaps = 0;

      // Back on the reset settings: a fresh string, queries at its ends and
      // beyond, then a begin that empties it again.
      set_hashes(RST_BASE_FIRST, RST_BASE_SECOND, RST_MODULUS_FIRST, RST_MODULUS_SECOND);
      queue_item(MODE_BEGIN, 8'h00, 12'd0, 12'd0);
      for (int i = 0; i < 30; i++)
         queue_item(MODE_APPEND, 8'($urandom), 12'd0, 12'd0);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd29);
      queue_item(MODE_QUERY, 8'h00, 12'd29, 12'd29);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd30);
      for (int i = 0; i < 10; i++) queue_query();
      queue_item(MODE_BEGIN, 8'h00, 12'd0, 12'd0);
      queue_item(MODE_QUERY, 8'h00, 12'd0, 12'd0);
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d items: %0d begins, %0d valid queries, %0d bad ranges, %0d full",
               items_taken, begin_count, valid_queries, range_count, full_count);
      $display("%0d results checked over several base and modulus settings", results_seen);
      if (error_count == 0 && owed_hashes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #1000ms;
      $display("timeout with %0d results outstanding", owed_hashes.size());
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

@@ double_mod_substring_hash_top.f @@
rtl/core/dmsh_pkg.sv
rtl/core/dmsh_ram.sv
rtl/core/dmsh_mulmod.sv
rtl/core/dmsh_front.sv
rtl/core/dmsh_back.sv
rtl/core/double_mod_substring_hash_top.sv
tb/double_mod_substring_hash_top_tb.sv
